@@ hw/rtl/srg_pkg.sv @@
package srg_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [DataW-1:0] QMax = 32'h7FFF_FFFF;
  localparam logic [DataW-1:0] QMin = 32'h8000_0000;
  localparam logic [DataW-1:0] ScaleOne = 32'h0001_0000;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_OFFSET_FIRST  = 3'd0,
    CFG_OFFSET_SECOND = 3'd1,
    CFG_SCALE_FIRST   = 3'd2,
    CFG_SCALE_SECOND  = 3'd3,
    CFG_COMBINE_OP    = 3'd4,
    CFG_OFFSET_INSIDE = 3'd5,
    CFG_REVERSED      = 3'd6,
    CFG_UNUSED        = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    COMB_ADD = 2'd0,
    COMB_SUB = 2'd1,
    COMB_MUL = 2'd2,
    COMB_DIV = 2'd3
  } comb_op_t;

  typedef enum logic [1:0] {
    PH_ZERO    = 2'd0,
    PH_SEEDED  = 2'd1,
    PH_COMPUTE = 2'd2,
    PH_THREE   = 2'd3
  } phase_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_T1_PRE,
    ST_T1_MUL,
    ST_T1_POST,
    ST_T2_PRE,
    ST_T2_MUL,
    ST_T2_POST,
    ST_PROD,
    ST_COMB,
    ST_DIV,
    ST_DIV_FIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic signed [DataW-1:0] offset_first;
    logic signed [DataW-1:0] offset_second;
    logic signed [DataW-1:0] scale_first;
    logic signed [DataW-1:0] scale_second;
    comb_op_t                combine_op;
    logic                    offset_inside;
    logic                    reversed;
  } cfg_t;

  // divider control
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

  // saturate a 33-bit sum to 32 bits
  function automatic logic [DataW:0] sat33(input logic signed [DataW:0] x);
    logic [DataW:0] r;
    if (x[DataW] != x[DataW-1]) begin
      r = {1'b1, (x[DataW] ? QMin : QMax)};
    end else begin
      r = {1'b0, x[DataW-1:0]};
    end
    return r;
  endfunction

  // saturate a 64-bit product shifted right by 16 (floor) to 32 bits
  function automatic logic [DataW:0] satq(input logic signed [2*DataW-1:0] p);
    logic signed [2*DataW-17:0] s;
    logic [DataW:0] r;
    s = p[2*DataW-1:16];
    if (s > $signed({{(DataW-16){1'b0}}, QMax}) ||
        s < $signed({{(DataW-16){1'b1}}, QMin})) begin
      r = {1'b1, (s[2*DataW-17] ? QMin : QMax)};
    end else begin
      r = {1'b0, s[DataW-1:0]};
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/srg_if.sv @@
interface srg_in_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [srg_pkg::DataW-1:0]  seed_first;
  logic [srg_pkg::DataW-1:0]  seed_second;
  modport source (output valid, op, seed_first, seed_second, input ready);
  modport sink (input valid, op, seed_first, seed_second, output ready);
endinterface

interface srg_out_if;
  logic                       valid;
  logic                       ready;
  logic [srg_pkg::DataW-1:0]  value;
  logic                       overflow;
  logic                       divide_by_zero;
  modport source (output valid, value, overflow, divide_by_zero, input ready);
  modport sink (input valid, value, overflow, divide_by_zero, output ready);
endinterface

@@ hw/rtl/srg_cfg_regs.sv @@
module srg_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [srg_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [srg_pkg::DataW-1:0]           cfg_wdata,
  output srg_pkg::cfg_t                       cfg
);

  srg_pkg::cfg_t cfg_r;

  // register file, synchronous reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.offset_first  <= '0;
      cfg_r.offset_second <= '0;
      cfg_r.scale_first   <= srg_pkg::ScaleOne;
      cfg_r.scale_second  <= srg_pkg::ScaleOne;
      cfg_r.combine_op    <= srg_pkg::COMB_ADD;
      cfg_r.offset_inside <= 1'b0;
      cfg_r.reversed      <= 1'b0;
    end else if (cfg_we) begin
      unique case (srg_pkg::cfg_idx_t'(cfg_index))
        srg_pkg::CFG_OFFSET_FIRST:  cfg_r.offset_first  <= cfg_wdata;
        srg_pkg::CFG_OFFSET_SECOND: cfg_r.offset_second <= cfg_wdata;
        srg_pkg::CFG_SCALE_FIRST:   cfg_r.scale_first   <= cfg_wdata;
        srg_pkg::CFG_SCALE_SECOND:  cfg_r.scale_second  <= cfg_wdata;
        srg_pkg::CFG_COMBINE_OP:    cfg_r.combine_op    <= srg_pkg::comb_op_t'(cfg_wdata[1:0]);
        srg_pkg::CFG_OFFSET_INSIDE: cfg_r.offset_inside <= cfg_wdata[0];
        srg_pkg::CFG_REVERSED:      cfg_r.reversed      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hw/rtl/srg_divider.sv @@
module srg_divider (
  input  logic                              clk,
  input  logic                              rst_n,
  input  srg_pkg::div_ctl_t                 ctl_in,
  input  logic signed [srg_pkg::DataW-1:0]  num,
  input  logic signed [srg_pkg::DataW-1:0]  den,
  output srg_pkg::div_ctl_t                 ctl_out,
  output logic [srg_pkg::DataW:0]           quot
);

  // restoring radix-2 divide of |num|<<16 by |den|, one quotient bit a cycle
  localparam int unsigned NumW = srg_pkg::DataW + 16;
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0]          rem_r, rem_nxt;
  logic [NumW-1:0]          q_r, q_nxt;
  logic [NumW-1:0]          dvd_r, dvd_nxt;
  logic [srg_pkg::DataW-1:0] dabs_r, dabs_nxt;
  logic                     neg_r, neg_nxt;
  logic [CntW-1:0]          cnt_r, cnt_nxt;
  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;
  logic [NumW:0]            trial;
  logic [NumW-1:0]          nabs;
  logic signed [NumW:0]     sq;

  always_comb begin
    nabs = num[srg_pkg::DataW-1] ? NumW'(-{{16{num[srg_pkg::DataW-1]}}, num}) << 16
                                 : NumW'({{16{1'b0}}, num}) << 16;
    trial = {rem_r, dvd_r[NumW-1]} - {{(NumW-srg_pkg::DataW+1){1'b0}}, dabs_r};
  end

  // iteration control
  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    dvd_nxt  = dvd_r;
    dabs_nxt = dabs_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctl_in.start) begin
      rem_nxt  = '0;
      q_nxt    = '0;
      dvd_nxt  = nabs;
      dabs_nxt = den[srg_pkg::DataW-1] ? -den : den;
      neg_nxt  = num[srg_pkg::DataW-1] ^ den[srg_pkg::DataW-1];
      cnt_nxt  = CntW'(NumW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = dvd_r << 1;
      if (!trial[NumW]) begin
        rem_nxt = trial[NumW-1:0];
        q_nxt   = {q_r[NumW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[NumW-2:0], dvd_r[NumW-1]};
        q_nxt   = {q_r[NumW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    dvd_r  <= dvd_nxt;
    dabs_r <= dabs_nxt;
    neg_r  <= neg_nxt;
  end

  // sign and saturation of the quotient
  always_comb begin
    sq = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
    if (sq > $signed({{(NumW-srg_pkg::DataW+1){1'b0}}, srg_pkg::QMax})) begin
      quot = {1'b1, srg_pkg::QMax};
    end else if (sq < $signed({{(NumW-srg_pkg::DataW+1){1'b1}}, srg_pkg::QMin})) begin
      quot = {1'b1, srg_pkg::QMin};
    end else begin
      quot = {1'b0, sq[srg_pkg::DataW-1:0]};
    end
    ctl_out.start = 1'b0;
    ctl_out.busy  = busy_r;
    ctl_out.done  = done_r;
  end

endmodule

@@ hw/rtl/second_order_recurrence_generator_top.sv @@
// Second-order recurrence generator, Q16.16, one shared 32x32 multiplier.
// Load and the first advance after a load go from idle straight to output; add, subtract,
// multiply and divide first compute both terms, and a divide by a nonzero denominator then
// runs the 48-step radix-2 divider. The output is held until out_ch.ready.
// One transaction at a time; in.ready is high only in idle. rst_n is synchronous:
// configuration registers return to defaults, elements to zero, phase to computing.
module second_order_recurrence_generator_top (
  input  logic                               clk,
  input  logic                               rst_n,
  srg_in_if.sink                             in_ch,
  srg_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [srg_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [srg_pkg::DataW-1:0]          cfg_wdata
);

  localparam int unsigned W = srg_pkg::DataW;

  srg_pkg::cfg_t     cfg;
  srg_pkg::state_t   state_r, state_nxt;
  srg_pkg::phase_t   phase_r, phase_nxt;
  srg_pkg::div_ctl_t dctl_in, dctl_out;

  logic signed [W-1:0]   older_r, older_nxt, newer_r, newer_nxt;
  logic signed [W-1:0]   e_r, e_nxt, a_r, a_nxt, b_r, b_nxt;
  logic signed [W-1:0]   mx_r, mx_nxt, my_r, my_nxt;
  logic signed [2*W-1:0] prod_r;
  logic [W-1:0]          res_r, res_nxt;
  logic                  ovf_r, ovf_nxt, dz_r, dz_nxt;
  logic                  ovalid_r, ovalid_nxt;
  logic [W:0]            sat_pre, sat_post, sat_mul, sat_comb;
  logic [W:0]            quot;

  srg_cfg_regs u_cfg (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .cfg(cfg)
  );

  srg_divider u_div (
    .clk(clk), .rst_n(rst_n), .ctl_in(dctl_in), .num(a_r), .den(b_r),
    .ctl_out(dctl_out), .quot(quot)
  );

  // shared multiplier, registered
  always_ff @(posedge clk) begin
    prod_r <= mx_r * my_r;
  end

  // term arithmetic helpers
  always_comb begin
    logic signed [W-1:0] off;
    logic is_first;
    is_first = (state_r == srg_pkg::ST_T1_PRE) || (state_r == srg_pkg::ST_T1_POST);
    off = is_first ? cfg.offset_first : cfg.offset_second;
    sat_pre  = srg_pkg::sat33({e_r[W-1], e_r} + {off[W-1], off});
    sat_mul  = srg_pkg::satq(prod_r);
    // offset added at full product precision, saturated once
    sat_post = srg_pkg::satq(prod_r + {{16{off[W-1]}}, off, 16'b0});
    unique case (cfg.combine_op)
      srg_pkg::COMB_ADD: sat_comb = srg_pkg::sat33({a_r[W-1], a_r} + {b_r[W-1], b_r});
      srg_pkg::COMB_SUB: sat_comb = srg_pkg::sat33({a_r[W-1], a_r} - {b_r[W-1], b_r});
      default:           sat_comb = sat_mul;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      srg_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          if (!in_ch.op || phase_r == srg_pkg::PH_SEEDED) begin
            state_nxt = srg_pkg::ST_OUT;
          end else begin
            state_nxt = srg_pkg::ST_T1_PRE;
          end
        end
      end
      srg_pkg::ST_T1_PRE:  state_nxt = srg_pkg::ST_T1_MUL;
      srg_pkg::ST_T1_MUL:  state_nxt = srg_pkg::ST_T1_POST;
      srg_pkg::ST_T1_POST: state_nxt = srg_pkg::ST_T2_PRE;
      srg_pkg::ST_T2_PRE:  state_nxt = srg_pkg::ST_T2_MUL;
      srg_pkg::ST_T2_MUL:  state_nxt = srg_pkg::ST_T2_POST;
      srg_pkg::ST_T2_POST: begin
        state_nxt = (cfg.combine_op == srg_pkg::COMB_MUL ||
                     (cfg.combine_op == srg_pkg::COMB_DIV && b_nxt != '0)) ?
                    srg_pkg::ST_PROD : srg_pkg::ST_COMB;
      end
      srg_pkg::ST_PROD: begin
        state_nxt = (cfg.combine_op == srg_pkg::COMB_DIV) ?
                    srg_pkg::ST_DIV : srg_pkg::ST_COMB;
      end
      srg_pkg::ST_COMB:    state_nxt = srg_pkg::ST_OUT;
      srg_pkg::ST_DIV:     if (dctl_out.done) state_nxt = srg_pkg::ST_DIV_FIN;
      srg_pkg::ST_DIV_FIN: state_nxt = srg_pkg::ST_OUT;
      srg_pkg::ST_OUT:     if (out_ch.ready) state_nxt = srg_pkg::ST_IDLE;
      default:             state_nxt = srg_pkg::ST_IDLE;
    endcase
  end

  // datapath outputs
  always_comb begin
    older_nxt  = older_r;
    newer_nxt  = newer_r;
    phase_nxt  = phase_r;
    e_nxt      = e_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    mx_nxt     = mx_r;
    my_nxt     = my_r;
    res_nxt    = res_r;
    ovf_nxt    = ovf_r;
    dz_nxt     = dz_r;
    ovalid_nxt = ovalid_r;
    dctl_in    = '0;
    unique case (state_r)
      srg_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          ovf_nxt = 1'b0;
          dz_nxt  = 1'b0;
          if (!in_ch.op) begin
            older_nxt  = in_ch.seed_first;
            newer_nxt  = in_ch.seed_second;
            phase_nxt  = srg_pkg::PH_SEEDED;
            res_nxt    = in_ch.seed_first;
            ovalid_nxt = 1'b1;
          end else if (phase_r == srg_pkg::PH_SEEDED) begin
            phase_nxt  = srg_pkg::PH_COMPUTE;
            res_nxt    = newer_r;
            ovalid_nxt = 1'b1;
          end else begin
            e_nxt = cfg.reversed ? older_r : newer_r;
          end
        end
      end
      srg_pkg::ST_T1_PRE, srg_pkg::ST_T2_PRE: begin
        mx_nxt = (state_r == srg_pkg::ST_T1_PRE) ? cfg.scale_first : cfg.scale_second;
        if (cfg.offset_inside) begin
          my_nxt  = sat_pre[W-1:0];
          ovf_nxt = ovf_r | sat_pre[W];
        end else begin
          my_nxt = e_r;
        end
      end
      srg_pkg::ST_T1_POST, srg_pkg::ST_T2_POST: begin
        if (cfg.offset_inside) begin
          res_nxt = sat_mul[W-1:0];
          ovf_nxt = ovf_r | sat_mul[W];
        end else begin
          res_nxt = sat_post[W-1:0];
          ovf_nxt = ovf_r | sat_post[W];
        end
        if (state_r == srg_pkg::ST_T1_POST) begin
          a_nxt = res_nxt;
          e_nxt = cfg.reversed ? newer_r : older_r;
        end else begin
          b_nxt  = res_nxt;
          mx_nxt = a_r;
          my_nxt = res_nxt;
        end
      end
      // product of the terms in flight; divider starts from registered terms
      srg_pkg::ST_PROD: begin
        if (cfg.combine_op == srg_pkg::COMB_DIV) begin
          dctl_in.start = 1'b1;
        end
      end
      srg_pkg::ST_COMB: begin
        if (cfg.combine_op == srg_pkg::COMB_DIV) begin
          dz_nxt  = 1'b1;
          res_nxt = (a_r == '0) ? '0 : (a_r[W-1] ? srg_pkg::QMin : srg_pkg::QMax);
        end else begin
          res_nxt = sat_comb[W-1:0];
          ovf_nxt = ovf_r | sat_comb[W];
        end
        older_nxt  = newer_r;
        newer_nxt  = res_nxt;
        phase_nxt  = srg_pkg::PH_COMPUTE;
        ovalid_nxt = 1'b1;
      end
      srg_pkg::ST_DIV_FIN: begin
        res_nxt    = quot[W-1:0];
        ovf_nxt    = ovf_r | quot[W];
        older_nxt  = newer_r;
        newer_nxt  = res_nxt;
        phase_nxt  = srg_pkg::PH_COMPUTE;
        ovalid_nxt = 1'b1;
      end
      srg_pkg::ST_OUT: begin
        if (out_ch.ready) ovalid_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= srg_pkg::ST_IDLE;
      phase_r  <= srg_pkg::PH_COMPUTE;
      older_r  <= '0;
      newer_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      older_r  <= older_nxt;
      newer_r  <= newer_nxt;
      ovalid_r <= ovalid_nxt;
    end
    e_r   <= e_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    mx_r  <= mx_nxt;
    my_r  <= my_nxt;
    res_r <= res_nxt;
    ovf_r <= ovf_nxt;
    dz_r  <= dz_nxt;
  end

  assign in_ch.ready           = (state_r == srg_pkg::ST_IDLE);
  assign out_ch.valid          = ovalid_r;
  assign out_ch.value          = res_r;
  assign out_ch.overflow       = ovf_r;
  assign out_ch.divide_by_zero = dz_r;

endmodule
